// File: design/kf3_pkg.sv
// Shared constants, command/status structs and state codes of the three-axis Kalman filter.
`timescale 1ns / 1ps
`default_nettype none
package kf3_pkg;

    localparam int AXES_DEF  = 3;   // default axis count
    localparam int MAX_AXES  = 3;   // lanes on the stream words
    localparam int DATA_W    = 32;
    localparam int AXIS_W    = 2;   // enough for MAX_AXES
    localparam int CFG_IDX_W = 2;
    localparam int GAIN_W    = 17;  // Q1.16, 0 .. 1.0
    localparam int DIV_STEPS = 17;  // one quotient bit per step
    localparam int CNT_W     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR      = 2'd2;

    localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd65;
    localparam logic [DATA_W-1:0] MEAS_NOISE_RST    = 32'd65536;
    localparam logic [DATA_W-1:0] INIT_VAR_RST      = 32'd65536;
    localparam logic [GAIN_W-1:0] GAIN_ONE          = 17'h10000;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOAD = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_UPD  = 6'b010000,
        ST_PUSH = 6'b100000
    } t_state;

    typedef struct packed {
        logic              capture;
        logic              load;
        logic              div_step;
        logic              div_first;
        logic              mul;
        logic              upd;
        logic              push;
        logic [AXIS_W-1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_status;

endpackage
`default_nettype wire

// File: design/kf3_ctrl.sv
// Sequencer of the three-axis Kalman filter: walks axes through load, divide, multiply, update.
`timescale 1ns / 1ps
`default_nettype none
module kf3_ctrl
    import kf3_pkg::*;
#(
    parameter int NUM_AX = AXES_DEF
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_s_tvalid,
    output logic    o_s_tready,
    input  wire     i_m_tready,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output t_state  o_state
);

    t_state            r_state, n_state;
    logic [AXIS_W-1:0] r_axis, n_axis;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.axis = r_axis;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_axis  = '0;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_cnt == '0);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                if (r_axis == AXIS_W'(NUM_AX - 1)) begin
                    n_state = ST_PUSH;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = ST_LOAD;
                end
            end
            ST_PUSH: begin
                // wait for the output register to free up
                if (!i_status.out_full || i_m_tready) begin
                    o_cmd.push = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_cnt   <= n_cnt;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_state    = r_state;

endmodule
`default_nettype wire

// File: design/kf3_dpath.sv
// Datapath of the three-axis Kalman filter: state, config, divider, multipliers, output word.
`timescale 1ns / 1ps
`default_nettype none
module kf3_dpath
    import kf3_pkg::*;
#(
    parameter int NUM_AX = AXES_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    input  wire  [MAX_AXES*DATA_W-1:0]    i_s_tdata,
    input  wire                           i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]          i_cfg_addr,
    input  wire  [DATA_W-1:0]             i_cfg_wdata,
    output logic                          o_m_tvalid,
    input  wire                           i_m_tready,
    output logic [MAX_AXES*DATA_W-1:0]    o_m_tdata
);

    localparam int AW = (NUM_AX > 1) ? $clog2(NUM_AX) : 1;

    logic [AW-1:0] ax;
    assign ax = i_cmd.axis[AW-1:0];

    logic [DATA_W-1:0]        r_q, r_r;
    logic signed [DATA_W-1:0] r_sample [NUM_AX];
    logic signed [DATA_W-1:0] r_est    [NUM_AX];
    logic [DATA_W-1:0]        r_var    [NUM_AX];

    logic [DATA_W-1:0]        r_p;
    logic signed [DATA_W-1:0] r_e;
    logic [DATA_W:0]          r_den;
    logic [DATA_W:0]          r_rem;
    logic signed [DATA_W:0]   r_diff;
    logic [GAIN_W-1:0]        r_gain;
    logic signed [50:0]       r_pe;
    logic [48:0]              r_pv;

    logic                      r_out_valid;
    logic [MAX_AXES*DATA_W-1:0] r_out_data;

    // config; initial_variance only matters at reset, which reloads its reset value anyway
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= PROCESS_NOISE_RST;
            r_r <= MEAS_NOISE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PROCESS_NOISE: r_q <= i_cfg_wdata;
                CFG_MEAS_NOISE:    r_r <= i_cfg_wdata;
                CFG_INIT_VAR:      r_q <= r_q;
                default:           r_q <= r_q;
            endcase
        end
    end

    // divider step: restoring, one quotient bit a cycle
    logic [DATA_W+1:0] div_t;
    logic              div_ge;
    always_comb begin
        div_t  = i_cmd.div_first ? {1'b0, r_rem} : {r_rem, 1'b0};
        div_ge = (r_den != '0) && (div_t >= {1'b0, r_den});
    end

    // update arithmetic
    logic signed [34:0] est_step;
    logic signed [35:0] est_sum;
    logic [DATA_W-1:0]  est_sat;
    logic [33:0]        var_sum;
    logic [DATA_W-1:0]  var_sat;
    logic signed [50:0] pe_c;
    logic [48:0]        pv_c;
    logic [GAIN_W-1:0]  one_minus_k;
    always_comb begin
        one_minus_k = GAIN_ONE - r_gain;
        pe_c = 51'($signed({1'b0, r_gain})) * 51'(r_diff);
        pv_c = 49'(one_minus_k) * 49'(r_p);
        est_step = r_pe[50:16];         // arithmetic shift: floor
        est_sum  = {{4{r_e[DATA_W-1]}}, r_e} + {est_step[34], est_step};
        if (!est_sum[35] && (|est_sum[34:31])) begin
            est_sat = 32'h7FFF_FFFF;
        end else if (est_sum[35] && !(&est_sum[34:31])) begin
            est_sat = 32'h8000_0000;
        end else begin
            est_sat = est_sum[31:0];
        end
        var_sum = {1'b0, r_pv[48:16]} + {2'b00, r_q};
        var_sat = (|var_sum[33:32]) ? 32'hFFFF_FFFF : var_sum[31:0];
    end

    genvar g;
    generate
        for (g = 0; g < NUM_AX; g++) begin : g_axis
            always_ff @(posedge i_clk) begin
                if (i_cmd.capture) begin
                    r_sample[g] <= i_s_tdata[g*DATA_W +: DATA_W];
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_est[g] <= '0;
                    r_var[g] <= INIT_VAR_RST;
                end else if (i_cmd.upd && (ax == AW'(g))) begin
                    r_est[g] <= est_sat;
                    r_var[g] <= var_sat;
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p    <= r_var[ax];
            r_e    <= r_est[ax];
            r_den  <= {1'b0, r_var[ax]} + {1'b0, r_r};
            r_diff <= {r_sample[ax][DATA_W-1], r_sample[ax]} - {r_est[ax][DATA_W-1], r_est[ax]};
            r_rem  <= {1'b0, r_var[ax]};
            r_gain <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= div_ge ? 33'(div_t - {1'b0, r_den}) : div_t[DATA_W:0];
            r_gain <= {r_gain[GAIN_W-2:0], div_ge};
        end
        if (i_cmd.mul) begin
            r_pe <= pe_c;
            r_pv <= pv_c;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    generate
        for (g = 0; g < MAX_AXES; g++) begin : g_lane
            if (g < NUM_AX) begin : g_live
                always_ff @(posedge i_clk) begin
                    if (i_cmd.push) begin
                        r_out_data[g*DATA_W +: DATA_W] <= r_est[g];
                    end
                end
            end else begin : g_idle
                always_ff @(posedge i_clk) begin
                    if (i_cmd.push) begin
                        r_out_data[g*DATA_W +: DATA_W] <= '0;
                    end
                end
            end
        end
    endgenerate

    assign o_m_tvalid        = r_out_valid;
    assign o_m_tdata         = r_out_data;
    assign o_status.out_full = r_out_valid;

endmodule
`default_nettype wire

// File: design/scalar_kalman_filter_3axis.sv
// Top level of the three-axis scalar Kalman filter.
// Usage:
//   Input stream (i_s_*): one word per three-axis sample, Q16.16 signed per axis.
//   Output stream (o_m_*): one word of updated estimates per input word.
//   Config port: i_cfg_we/i_cfg_addr/i_cfg_wdata, index 0 process noise,
//   1 measurement noise, 2 initial variance; write only while idle.
// Sequence:
//   Each axis goes through load, 17 gain division steps, multiply, update.
//   The 17-step restoring divider is shared by the axes.
//   A word is accepted only in the idle state: the next word is taken once the
//   last word's result is pushed into the output register, and the push waits
//   while that register still holds a word the receiver has not taken.
// Reset (synchronous, active low): estimates go to zero, variances to 1.0,
//   noises to their reset values, the output register empties.
// Stall: the finished word waits in the output register; the next word is
//   accepted and processed meanwhile, and is held back only at the very end
//   until the register frees up.
// Axes beyond AXES (at most three are filtered) read as zero.
`timescale 1ns / 1ps
`default_nettype none
module scalar_kalman_filter_3axis
    import kf3_pkg::*;
#(
    parameter int AXES = AXES_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_s_tvalid,
    output logic                        o_s_tready,
    input  wire  [MAX_AXES*DATA_W-1:0]  i_s_tdata,   // sample_x, sample_y, sample_z
    output logic                        o_m_tvalid,
    input  wire                         i_m_tready,
    output logic [MAX_AXES*DATA_W-1:0]  o_m_tdata,   // estimate_x, estimate_y, estimate_z
    input  wire                         i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]        i_cfg_addr,
    input  wire  [DATA_W-1:0]           i_cfg_wdata
);

    localparam int NUM_AX = (AXES < MAX_AXES) ? AXES : MAX_AXES;

    t_cmd    cmd;
    t_status status;
    t_state  state;

    kf3_ctrl #(
        .NUM_AX (NUM_AX)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_state    (state)
    );

    kf3_dpath #(
        .NUM_AX (NUM_AX)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

`ifndef SYNTHESIS
    // an accepted word starts the per-axis sequence
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (state == ST_LOAD))
        else $error("accepted word did not start processing");

    // a result is loaded only at the end of the push state
    a_result_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |=> (o_m_tvalid && (state == ST_IDLE)))
        else $error("result word not presented after push");

    // push never overwrites a word the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> (!o_m_tvalid || i_m_tready))
        else $error("output word overwritten");
`endif

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for the three-axis scalar Kalman filter: directed table, then random noise settings.
`timescale 1ns / 1ps
module tb;
    import kf3_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // no register behind it
    localparam int SETTLE_CYCLES  = 64;    // longer than one word takes to pass through the block
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 8;
    localparam int WORDS_PER_PHASE = 112;

    typedef struct packed {
        logic [DATA_W-1:0] z;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] x;
    } t_axes3;

    typedef enum {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]  val;
        t_axes3             smp;
        bit                 typed;
        t_axes3             want;
    } t_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_s_tvalid;
    logic                       o_s_tready;
    logic [MAX_AXES*DATA_W-1:0] i_s_tdata;
    logic                       o_m_tvalid;
    logic                       i_m_tready;
    logic [MAX_AXES*DATA_W-1:0] o_m_tdata;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_addr;
    logic [DATA_W-1:0]          i_cfg_wdata;

    scalar_kalman_filter_3axis dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // sample_x, sample_y, sample_z
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // estimate_x, estimate_y, estimate_z
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // filter state as the block should hold it
    logic signed [DATA_W-1:0] est_q[MAX_AXES];
    logic [DATA_W-1:0]        var_q[MAX_AXES];
    logic [DATA_W-1:0]        q_noise;
    logic [DATA_W-1:0]        r_noise;
    logic [DATA_W-1:0]        init_var_shadow;

    t_axes3      pending_estimates[$];
    t_row        directed_rows[$];
    logic [DATA_W-1:0] last_sample[MAX_AXES];
    int          sender_idle_pct;
    int          recv_stall_pct;
    int          fail_count;
    int          words_sent;
    int          words_checked;
    int          quiet_cycles;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // one filter step over all axes; returns the estimates the block must emit
    task automatic kalman_step(input t_axes3 smp, output t_axes3 est);
        logic [DATA_W-1:0] s[MAX_AXES];
        logic [63:0] p;
        logic [63:0] den;
        logic [63:0] gain;
        logic [63:0] v;
        longint diff;
        longint nxt;
        s[0] = smp.x;
        s[1] = smp.y;
        s[2] = smp.z;
        for (int a = 0; a < MAX_AXES; a++) begin
            p = {32'd0, var_q[a]};
            den = p + {32'd0, r_noise};
            gain = (den != 0) ? (p << 16) / den : 64'd0;
            if (gain > 64'd65536)
                gain = 64'd65536;
            diff = longint'($signed(s[a])) - longint'(est_q[a]);
            nxt = longint'(est_q[a]) + ((longint'(gain) * diff) >>> 16);
            if (nxt > longint'(32'sh7FFFFFFF))
                nxt = longint'(32'sh7FFFFFFF);
            if (nxt < -longint'(64'h80000000))
                nxt = -longint'(64'h80000000);
            est_q[a] = nxt[DATA_W-1:0];
            v = ((64'd65536 - gain) * p) >> 16;
            v = v + {32'd0, q_noise};
            if (v > 64'hFFFFFFFF)
                v = 64'hFFFFFFFF;
            var_q[a] = v[DATA_W-1:0];
        end
        est = '{z: est_q[2], y: est_q[1], x: est_q[0]};
    endtask

    task automatic send_samples(input t_axes3 smp, input bit typed, input t_axes3 want);
        t_axes3 est;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= smp;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        kalman_step(smp, est);
        pending_estimates.push_back(typed ? want : est);
        words_sent++;
        last_sample[0] = smp.x;
        last_sample[1] = smp.y;
        last_sample[2] = smp.z;
        @(negedge i_clk);
    endtask

    // called at a falling edge; leaves the block idle
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_estimates.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
        case (idx)
            CFG_PROCESS_NOISE: q_noise = val;
            CFG_MEAS_NOISE:    r_noise = val;
            CFG_INIT_VAR:      init_var_shadow = val;   // the block keeps no register for it; reset loads INIT_VAR_RST
            default: ;
        endcase
    endtask

    task automatic add_sample(input logic [DATA_W-1:0] x, y, z);
        directed_rows.push_back('{ROW_SAMPLE, CFG_SPARE, '0, '{z: z, y: y, x: x}, 1'b0, '0});
    endtask

    task automatic add_checked(input logic [DATA_W-1:0] x, y, z, wx, wy, wz);
        directed_rows.push_back('{ROW_SAMPLE, CFG_SPARE, '0, '{z: z, y: y, x: x}, 1'b1,
                                  '{z: wz, y: wy, x: wx}});
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        directed_rows.push_back('{ROW_WRITE, idx, val, '0, 1'b0, '0});
    endtask

    // mix of full-range words, IMU-like drift, rails and small values
    function automatic logic [DATA_W-1:0] pick_sample(input logic [DATA_W-1:0] prev);
        int unsigned r;
        int delta;
        r = $urandom_range(99);
        delta = int'($urandom_range(0, 262143)) - 131071;
        if (r < 35)
            return $urandom;
        if (r < 65)
            return prev + DATA_W'(delta);
        if (r < 80) begin
            case ($urandom_range(3))
                0: return 32'h7FFFFFFF;
                1: return 32'h80000000;
                2: return 32'h00000000;
                default: return 32'hFFFFFFFF;
            endcase
        end
        return DATA_W'($urandom_range(0, 32'h7FFFF)) - 32'h40000;
    endfunction

    always @(negedge i_clk)
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        t_axes3 got;
        t_axes3 want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (pending_estimates.size() == 0) begin
                $error("estimate word with none expected: %h", got);
                fail_count++;
            end else begin
                want = pending_estimates.pop_front();
                words_checked++;
                if (got.x !== want.x) begin
                    $error("estimate_x: expected %0d, got %0d", $signed(want.x), $signed(got.x));
                    fail_count++;
                end
                if (got.y !== want.y) begin
                    $error("estimate_y: expected %0d, got %0d", $signed(want.y), $signed(got.y));
                    fail_count++;
                end
                if (got.z !== want.z) begin
                    $error("estimate_z: expected %0d, got %0d", $signed(want.z), $signed(got.z));
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL scalar_kalman_filter_3axis");
            $finish;
        end
    end

    initial begin
        t_axes3 smp;
        i_rst_n         = 1'b0;
        i_s_tvalid      = 1'b0;
        i_s_tdata       = '0;
        i_m_tready      = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = '0;
        i_cfg_wdata     = '0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        fail_count      = 0;
        words_sent      = 0;
        words_checked   = 0;
        quiet_cycles    = 0;
        q_noise         = PROCESS_NOISE_RST;
        r_noise         = MEAS_NOISE_RST;
        init_var_shadow = INIT_VAR_RST;
        for (int a = 0; a < MAX_AXES; a++) begin
            est_q[a]       = '0;
            var_q[a]       = INIT_VAR_RST;
            last_sample[a] = '0;
        end

        // P = R = 1.0 after reset, so the gain is one half
        add_checked(32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h3FFFFFFF, 32'hC0000000, 32'h0);
        add_sample(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
        add_sample(32'h0, 32'h0, 32'h1);
        add_sample(32'h00010000, 32'hFFFF0000, 32'h12345678);
        add_write(CFG_INIT_VAR, 32'h0);
        add_write(CFG_SPARE, 32'hFFFFFFFF);
        add_sample(32'hAAAAAAAA, 32'h55555555, 32'h80000001);
        // no noise at all: unit gain, then the variance is zero and so is P + R
        add_write(CFG_PROCESS_NOISE, 32'h0);
        add_write(CFG_MEAS_NOISE, 32'h0);
        add_checked(32'h00050000, 32'hFFFD0000, 32'h7FFFFFFF,
                    32'h00050000, 32'hFFFD0000, 32'h7FFFFFFF);
        add_checked(32'h80000000, 32'h0, 32'h1234, 32'h00050000, 32'hFFFD0000, 32'h7FFFFFFF);
        add_checked(32'h7FFFFFFF, 32'hFFFFFFFF, 32'h0,
                    32'h00050000, 32'hFFFD0000, 32'h7FFFFFFF);
        // full-scale noise drives the variance into saturation
        add_write(CFG_PROCESS_NOISE, 32'hFFFFFFFF);
        add_write(CFG_MEAS_NOISE, 32'hFFFFFFFF);
        add_write(CFG_INIT_VAR, 32'hFFFFFFFF);
        add_sample(32'h80000000, 32'h7FFFFFFF, 32'h0);
        add_sample(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
        add_sample(32'h0, 32'h0, 32'h0);
        add_sample(32'hFFFFFFFF, 32'h1, 32'h80000000);
        add_write(CFG_PROCESS_NOISE, 32'h0);
        add_write(CFG_MEAS_NOISE, 32'h1);
        add_sample(32'h7FFFFFFF, 32'h80000000, 32'h00008000);
        add_sample(32'h80000000, 32'h7FFFFFFF, 32'hFFFF8000);
        add_write(CFG_PROCESS_NOISE, PROCESS_NOISE_RST);
        add_write(CFG_MEAS_NOISE, MEAS_NOISE_RST);
        add_sample(32'h00020000, 32'hFFFE0000, 32'h00000001);
        add_sample(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                wait_drained();
                write_reg(directed_rows[i].idx, directed_rows[i].val);
            end else begin
                send_samples(directed_rows[i].smp, directed_rows[i].typed,
                             directed_rows[i].want);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    write_reg(CFG_PROCESS_NOISE, PROCESS_NOISE_RST);
                    write_reg(CFG_MEAS_NOISE, MEAS_NOISE_RST);
                    write_reg(CFG_INIT_VAR, 32'h0);
                end
                1: begin
                    write_reg(CFG_PROCESS_NOISE, 32'h0);
                    write_reg(CFG_MEAS_NOISE, 32'h0);
                end
                2: begin
                    write_reg(CFG_PROCESS_NOISE, 32'hFFFFFFFF);
                    write_reg(CFG_MEAS_NOISE, 32'hFFFFFFFF);
                    write_reg(CFG_INIT_VAR, 32'hFFFFFFFF);
                end
                3: begin
                    write_reg(CFG_PROCESS_NOISE, $urandom);
                    write_reg(CFG_MEAS_NOISE, $urandom);
                end
                4: begin
                    write_reg(CFG_PROCESS_NOISE, $urandom_range(0, 1023));
                    write_reg(CFG_MEAS_NOISE, $urandom_range(0, 32'h3FFFF));
                end
                5: begin
                    write_reg(CFG_PROCESS_NOISE, 32'h0);
                    write_reg(CFG_MEAS_NOISE, $urandom);
                end
                6: begin
                    write_reg(CFG_PROCESS_NOISE, $urandom);
                    write_reg(CFG_MEAS_NOISE, 32'h0);
                end
                default: begin
                    write_reg(CFG_PROCESS_NOISE, $urandom_range(0, 65535));
                    write_reg(CFG_MEAS_NOISE, $urandom_range(0, 32'h1FFFF));
                end
            endcase
            write_reg(CFG_INIT_VAR, $urandom);
            write_reg(CFG_SPARE, $urandom);

            // free-flowing, sparse source, heavy back-pressure, light on both
            case (ph % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin sender_idle_pct = 9; recv_stall_pct = 9; end
            endcase

            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                smp.x = pick_sample(last_sample[0]);
                smp.y = pick_sample(last_sample[1]);
                smp.z = pick_sample(last_sample[2]);
                send_samples(smp, 1'b0, '0);
            end
        end

        wait_drained();
        $display("Filtered %0d three-axis words, %0d checked, over %0d noise settings", words_sent,
                 words_checked, RANDOM_PHASES + 5);
        $display("including zero-noise, saturated-variance and stalled-output runs.");
        if (fail_count == 0) begin
            $display("PASS scalar_kalman_filter_3axis");
        end else begin
            $display("FAIL scalar_kalman_filter_3axis");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/kf3_pkg.sv
design/kf3_ctrl.sv
design/kf3_dpath.sv
design/scalar_kalman_filter_3axis.sv
tb/sv/tb.sv
